/* rtl/core/rtypr_pkg.sv */
// ----------------------------------------------------------------------------
// rtypr_pkg: shared constants and tables for the rotation to Euler angle block
// Widths, pipeline latencies, CORDIC arctangent table and angle constants.
// ----------------------------------------------------------------------------
package rtypr_pkg;

  localparam int IN_W       = 16;           // matrix element width, Q1.14
  localparam int ANG_FRAC   = 7;            // fraction bits of output angles
  localparam int ACC_FRAC   = 24;           // fraction bits of the angle accumulator
  localparam int STEPS      = 24;           // CORDIC micro-rotations
  localparam int NORM_N     = 6;            // normalizing shift stages (32,16,8,4,2,1)
  localparam int CIN_W      = 34;           // CORDIC operand width at its input
  localparam int CW         = 46;           // CORDIC x/y datapath width
  localparam int MAG_W      = 42;           // magnitude tracked while normalizing
  localparam int ZW         = 35;           // angle accumulator width
  localparam int ROUND_SH   = ACC_FRAC - ANG_FRAC;
  localparam int RW         = ZW - ROUND_SH;
  localparam int OUT_W      = 16;           // yaw and roll field width
  localparam int PITCH_W    = 15;           // pitch field width
  localparam int PROD_W     = 2 * IN_W;
  localparam int SQ_W       = 32;
  localparam int RAD_W      = 48;           // radicand: sum of squares times 2^16
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int ISQ_LAT    = ROOT_W;
  localparam int COR_NS     = 1 + NORM_N + STEPS;   // pre-stage, shifts, rotations
  localparam int COR_LAT    = COR_NS + 1;           // plus rounding register
  localparam int LAT        = 2 + ISQ_LAT + COR_LAT + 1;
  localparam int DATA_IN_W  = 7 * IN_W;
  localparam int DATA_OUT_W = 48;

  localparam logic signed [ZW-1:0] Z_180 = ZW'(64'sd180 <<< ACC_FRAC);
  localparam logic signed [ZW-1:0] Z_90  = ZW'(64'sd90 <<< ACC_FRAC);
  localparam logic signed [RW-1:0] HALF_TURN = RW'(180 * (2 ** ANG_FRAC));
  localparam logic signed [RW-1:0] FULL_TURN = RW'(360 * (2 ** ANG_FRAC));
  localparam logic signed [OUT_W-1:0] PITCH_LIM = OUT_W'(90 * (2 ** ANG_FRAC));

  // Shift applied by normalizing stage s.
  function automatic int norm_sh(input int s);
    return 32 >> s;
  endfunction

  // atan(2^-i) in degrees with ACC_FRAC fraction bits.
  function automatic logic signed [ZW-1:0] atan_tab(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = ZW'(64'd754974720);
      1:  v = ZW'(64'd445687602);
      2:  v = ZW'(64'd235489088);
      3:  v = ZW'(64'd119537938);
      4:  v = ZW'(64'd60000934);
      5:  v = ZW'(64'd30029717);
      6:  v = ZW'(64'd15018523);
      7:  v = ZW'(64'd7509720);
      8:  v = ZW'(64'd3754917);
      9:  v = ZW'(64'd1877466);
      10: v = ZW'(64'd938734);
      11: v = ZW'(64'd469367);
      12: v = ZW'(64'd234684);
      13: v = ZW'(64'd117342);
      14: v = ZW'(64'd58671);
      15: v = ZW'(64'd29335);
      16: v = ZW'(64'd14668);
      17: v = ZW'(64'd7334);
      18: v = ZW'(64'd3667);
      19: v = ZW'(64'd1833);
      20: v = ZW'(64'd917);
      21: v = ZW'(64'd458);
      22: v = ZW'(64'd229);
      23: v = ZW'(64'd115);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/rtypr_isqrt.sv */
// ----------------------------------------------------------------------------
// rtypr_isqrt: pipelined integer square root
// Restoring digit-by-digit method, one result bit per register stage.
// ----------------------------------------------------------------------------
module rtypr_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rtypr_pkg::RAD_W-1:0]   rad,
  output logic [rtypr_pkg::ROOT_W-1:0]  root
);
  import rtypr_pkg::*;

  logic [RAD_W-1:0]  v_r    [0:ISQ_LAT-1];
  logic [REM_W-1:0]  rem_r  [0:ISQ_LAT-1];
  logic [ROOT_W-1:0] root_r [0:ISQ_LAT-1];
  logic [RAD_W-1:0]  v_nxt    [0:ISQ_LAT-1];
  logic [REM_W-1:0]  rem_nxt  [0:ISQ_LAT-1];
  logic [ROOT_W-1:0] root_nxt [0:ISQ_LAT-1];

  always_comb begin
    logic [RAD_W-1:0]  vp;
    logic [REM_W-1:0]  rp;
    logic [ROOT_W-1:0] qp;
    logic [REM_W-1:0]  rsh;
    logic [REM_W-1:0]  trial;
    for (int j = 0; j < ISQ_LAT; j++) begin
      if (j == 0) begin
        vp = rad;
        rp = '0;
        qp = '0;
      end else begin
        vp = v_r[j-1];
        rp = rem_r[j-1];
        qp = root_r[j-1];
      end
      rsh   = {rp[REM_W-3:0], vp[RAD_W-1 -: 2]};
      trial = {1'b0, qp, 2'b01};
      if (rsh >= trial) begin
        rem_nxt[j]  = rsh - trial;
        root_nxt[j] = {qp[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[j]  = rsh;
        root_nxt[j] = {qp[ROOT_W-2:0], 1'b0};
      end
      v_nxt[j] = {vp[RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < ISQ_LAT; j++) begin
        v_r[j]    <= v_nxt[j];
        rem_r[j]  <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
      end
    end
  end

  assign root = root_r[ISQ_LAT-1];

endmodule

/* rtl/core/rtypr_cordic.sv */
// ----------------------------------------------------------------------------
// rtypr_cordic: pipelined vectoring CORDIC arctangent
// Quadrant fold, normalizing shifts, one micro-rotation per stage, rounding.
// ----------------------------------------------------------------------------
module rtypr_cordic (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [rtypr_pkg::CIN_W-1:0]  y_in,
  input  logic signed [rtypr_pkg::CIN_W-1:0]  x_in,
  output logic signed [rtypr_pkg::OUT_W-1:0]  ang
);
  import rtypr_pkg::*;

  logic signed [CW-1:0] x_r   [0:COR_NS-1];
  logic signed [CW-1:0] y_r   [0:COR_NS-1];
  logic signed [ZW-1:0] z_r   [0:COR_NS-1];
  logic [MAG_W-1:0]     mag_r [0:COR_NS-1];
  logic                 sp_r  [0:COR_NS-1];
  logic signed [CW-1:0] x_nxt   [0:COR_NS-1];
  logic signed [CW-1:0] y_nxt   [0:COR_NS-1];
  logic signed [ZW-1:0] z_nxt   [0:COR_NS-1];
  logic [MAG_W-1:0]     mag_nxt [0:COR_NS-1];
  logic                 sp_nxt  [0:COR_NS-1];
  logic signed [OUT_W-1:0] ang_r;
  logic signed [OUT_W-1:0] ang_nxt;

  // Front stage: exact axis cases, fold left half-plane, magnitude.
  always_comb begin
    logic signed [CW-1:0] xe;
    logic signed [CW-1:0] ye;
    logic signed [CW-1:0] ya;
    logic signed [ZW-1:0] zs;
    logic signed [ZW-1:0] z0;
    xe = CW'(x_in);
    ye = CW'(y_in);
    if (y_in == '0) begin
      zs = (x_in < 0) ? Z_180 : '0;
    end else begin
      zs = (y_in > 0) ? Z_90 : -Z_90;
    end
    z0 = '0;
    if (x_in < 0) begin
      z0 = (y_in > 0) ? Z_180 : -Z_180;
      xe = -xe;
      ye = -ye;
    end
    ya = (ye < 0) ? -ye : ye;
    sp_nxt[0]  = (y_in == '0) || (x_in == '0);
    z_nxt[0]   = sp_nxt[0] ? zs : z0;
    x_nxt[0]   = xe;
    y_nxt[0]   = ye;
    mag_nxt[0] = (xe > ya) ? xe[MAG_W-1:0] : ya[MAG_W-1:0];
  end

  // Normalizing shifts, then micro-rotations.
  always_comb begin
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    int sh;
    int i;
    for (int k = 1; k < COR_NS; k++) begin
      x_nxt[k]   = x_r[k-1];
      y_nxt[k]   = y_r[k-1];
      z_nxt[k]   = z_r[k-1];
      mag_nxt[k] = mag_r[k-1];
      sp_nxt[k]  = sp_r[k-1];
      if (k <= NORM_N) begin
        sh = norm_sh(k - 1);
        if ((mag_r[k-1] >> (MAG_W - 1 - sh)) == '0) begin
          x_nxt[k]   = x_r[k-1] <<< sh;
          y_nxt[k]   = y_r[k-1] <<< sh;
          mag_nxt[k] = mag_r[k-1] << sh;
        end
      end else begin
        i  = k - 1 - NORM_N;
        dx = y_r[k-1] >>> i;
        dy = x_r[k-1] >>> i;
        if (!sp_r[k-1]) begin
          if (y_r[k-1] > 0) begin
            x_nxt[k] = x_r[k-1] + dx;
            y_nxt[k] = y_r[k-1] - dy;
            z_nxt[k] = z_r[k-1] + atan_tab(i);
          end else begin
            x_nxt[k] = x_r[k-1] - dx;
            y_nxt[k] = y_r[k-1] + dy;
            z_nxt[k] = z_r[k-1] - atan_tab(i);
          end
        end
      end
    end
  end

  // Round to nearest (ties up) and wrap into (-180, 180].
  always_comb begin
    logic signed [ZW-1:0] zr;
    logic signed [RW-1:0] r;
    zr = z_r[COR_NS-1] + ZW'(64'sd1 <<< (ROUND_SH - 1));
    r  = RW'(zr >>> ROUND_SH);
    if (r > HALF_TURN) begin
      r = r - FULL_TURN;
    end else if (r <= -HALF_TURN) begin
      r = r + FULL_TURN;
    end
    ang_nxt = r[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < COR_NS; k++) begin
        x_r[k]   <= x_nxt[k];
        y_r[k]   <= y_nxt[k];
        z_r[k]   <= z_nxt[k];
        mag_r[k] <= mag_nxt[k];
        sp_r[k]  <= sp_nxt[k];
      end
      ang_r <= ang_nxt;
    end
  end

  assign ang = ang_r;

endmodule

/* rtl/core/rotation_to_yaw_pitch_roll.sv */
// ----------------------------------------------------------------------------
// rotation_to_yaw_pitch_roll: rotation matrix to Z-Y-X Euler angles
// Fully pipelined conversion of seven Q1.14 matrix elements to yaw, pitch and
// roll in degrees with seven fraction bits.
// ----------------------------------------------------------------------------
// A new matrix beat can be accepted in every clock cycle while the output side
// is not stalled, and one angle beat leaves for each matrix beat, in order. The
// depth is set by the pitch path: the product and sum registers, a 24-stage
// square root for the horizontal norm, a 32-stage CORDIC (fold, six normalizing
// shifts, 24 micro-rotations, rounding) and the output register.
// Yaw and roll run through their own CORDIC pipelines in parallel and are held
// in a delay line so all three angles leave together. The whole pipeline
// advances only while the output register is empty or being taken, so a stall
// freezes every stage and nothing is lost or repeated. atan2(0,0) gives zero,
// angles lie in (-180, 180], and pitch is limited to plus or minus 90 degrees.
// ----------------------------------------------------------------------------
module rotation_to_yaw_pitch_roll (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata from bit 0 up: n_x, n_y, n_z, o_x, o_y, a_x, a_y (16 bits each)
  input  logic [rtypr_pkg::DATA_IN_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // tdata from bit 0 up: yaw_deg (16), pitch_deg (15), roll_deg (16), zero pad
  output logic [rtypr_pkg::DATA_OUT_W-1:0]     out_tdata
);
  import rtypr_pkg::*;

  logic en;
  logic vld_r [0:LAT-1];

  // Stage one: the matrix fields and the six products.
  logic signed [IN_W-1:0]   nx1_r, ny1_r, nz1_r, oy1_r, ay1_r;
  logic signed [PROD_W-1:0] nxx1_r, nyy1_r, axny1_r, aynx1_r, oynx1_r, oxny1_r;
  // Stage two: sum of squares, roll operands, yaw operands.
  logic [SQ_W-1:0]          sq2_r;
  logic signed [CIN_W-1:0]  num2_r, den2_r, nx2_r, ny2_r;
  logic signed [IN_W-1:0]   nz2_r;
  logic signed [IN_W-1:0]   nzd_r [0:ISQ_LAT-1];

  logic [ROOT_W-1:0]        hx;
  logic signed [CIN_W-1:0]  pit_y, pit_x;
  logic signed [OUT_W-1:0]  yaw_ang, pitch_ang, roll_ang;
  logic signed [OUT_W-1:0]  yawd_r  [0:ISQ_LAT-1];
  logic signed [OUT_W-1:0]  rolld_r [0:ISQ_LAT-1];
  logic signed [OUT_W-1:0]  pitch_sat;
  logic [DATA_OUT_W-1:0]    out_r;

  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k < LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [IN_W-1:0] nx, ny, ox, oy, ax, ay;
    nx = in_tdata[0*IN_W +: IN_W];
    ny = in_tdata[1*IN_W +: IN_W];
    ox = in_tdata[3*IN_W +: IN_W];
    oy = in_tdata[4*IN_W +: IN_W];
    ax = in_tdata[5*IN_W +: IN_W];
    ay = in_tdata[6*IN_W +: IN_W];
    if (en) begin
      nx1_r   <= nx;
      ny1_r   <= ny;
      nz1_r   <= in_tdata[2*IN_W +: IN_W];
      oy1_r   <= oy;
      ay1_r   <= ay;
      nxx1_r  <= nx * nx;
      nyy1_r  <= ny * ny;
      axny1_r <= ax * ny;
      aynx1_r <= ay * nx;
      oynx1_r <= oy * nx;
      oxny1_r <= ox * ny;

      sq2_r <= SQ_W'(nxx1_r) + SQ_W'(nyy1_r);
      // With no horizontal component, yaw is taken as zero: cos 1, sin 0.
      if (nx1_r == '0 && ny1_r == '0) begin
        num2_r <= -CIN_W'(ay1_r);
        den2_r <= CIN_W'(oy1_r);
      end else begin
        num2_r <= CIN_W'(axny1_r) - CIN_W'(aynx1_r);
        den2_r <= CIN_W'(oynx1_r) - CIN_W'(oxny1_r);
      end
      nx2_r <= CIN_W'(nx1_r);
      ny2_r <= CIN_W'(ny1_r);
      nz2_r <= nz1_r;

      // n_z waits for the square root; yaw and roll wait for pitch.
      nzd_r[0]   <= nz2_r;
      yawd_r[0]  <= yaw_ang;
      rolld_r[0] <= roll_ang;
      for (int k = 1; k < ISQ_LAT; k++) begin
        nzd_r[k]   <= nzd_r[k-1];
        yawd_r[k]  <= yawd_r[k-1];
        rolld_r[k] <= rolld_r[k-1];
      end

      out_r <= {1'b0, rolld_r[ISQ_LAT-1], pitch_sat[PITCH_W-1:0], yawd_r[ISQ_LAT-1]};
    end
  end

  // Horizontal norm scaled by 2^8, so it matches -n_z times 256.
  rtypr_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  ({sq2_r, 16'h0000}),
    .root (hx)
  );

  assign pit_y = -(CIN_W'(nzd_r[ISQ_LAT-1]) <<< 8);
  assign pit_x = CIN_W'(hx);

  rtypr_cordic u_yaw (
    .clk  (clk),
    .en   (en),
    .y_in (ny2_r),
    .x_in (nx2_r),
    .ang  (yaw_ang)
  );

  rtypr_cordic u_pitch (
    .clk  (clk),
    .en   (en),
    .y_in (pit_y),
    .x_in (pit_x),
    .ang  (pitch_ang)
  );

  rtypr_cordic u_roll (
    .clk  (clk),
    .en   (en),
    .y_in (num2_r),
    .x_in (den2_r),
    .ang  (roll_ang)
  );

  always_comb begin
    if (pitch_ang > PITCH_LIM) begin
      pitch_sat = PITCH_LIM;
    end else if (pitch_ang < -PITCH_LIM) begin
      pitch_sat = -PITCH_LIM;
    end else begin
      pitch_sat = pitch_ang;
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = out_r;

endmodule
